// ----- sv/aco_pu_pkg.sv -----
// Package for the pheromone update engine: operation codes, register
// indexes, field widths and fixed-point constants.
// No dependencies; used by the divider, the top level and the test bench.
package aco_pu_pkg;

    // Operation carried in the input item's tuser
    typedef enum logic [1:0] {
        OP_DEPOSIT = 2'd0,
        OP_COMMIT  = 2'd1,
        OP_READ    = 2'd2
    } op_t;

    // Configuration register indexes
    localparam logic [0:0] CFG_NUMERATOR = 1'b0;
    localparam logic [0:0] CFG_RETENTION = 1'b1;

    // Field widths
    localparam int CITY_W     = 5;
    localparam int LEN_W      = 24;
    localparam int VALUE_W    = 32;
    localparam int RET_W      = 16;
    localparam int DIVIDEND_W = VALUE_W + 4;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Fixed-point constants
    localparam logic [VALUE_W-1:0] ONE_Q16       = 32'h0001_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX     = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] NUMERATOR_RST = 32'h0001_0000;
    localparam logic [RET_W-1:0]   RETENTION_RST = 16'h8000;

endpackage

// ----- sv/aco_pu_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on nothing; used for the pheromone and accumulator stores.
module aco_pu_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write, and read with registered read data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/aco_pu_div.sv -----
// Serial restoring divider, one quotient bit per cycle, for the deposit amount.
// Depends on aco_pu_pkg for the dividend, divisor and step widths.
module aco_pu_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [aco_pu_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [aco_pu_pkg::LEN_W-1:0]      divisor,
    output logic                              done,
    output logic [aco_pu_pkg::DIVIDEND_W-1:0] quotient
);

    localparam logic [aco_pu_pkg::STEP_W-1:0] LAST_STEP =
        aco_pu_pkg::STEP_W'(aco_pu_pkg::DIV_STEPS - 1);

    logic                              busy_reg;
    logic                              done_reg;
    logic [aco_pu_pkg::STEP_W-1:0]     cnt_reg;
    logic [aco_pu_pkg::LEN_W-1:0]      rem_reg;
    logic [aco_pu_pkg::LEN_W-1:0]      dvs_reg;
    logic [aco_pu_pkg::DIVIDEND_W-1:0] quo_reg;

    logic [aco_pu_pkg::LEN_W:0]        rem_sh;
    logic [aco_pu_pkg::LEN_W+1:0]      trial;
    logic                              take;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        rem_sh = {rem_reg, quo_reg[aco_pu_pkg::DIVIDEND_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, dvs_reg};
        take   = !trial[aco_pu_pkg::LEN_W+1];
    end

    // Iterate from the top quotient bit down
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            // Flag the cycle after the last step
            done_reg <= busy_reg && !start && (cnt_reg == LAST_STEP);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= take ? trial[aco_pu_pkg::LEN_W-1:0]
                                : rem_sh[aco_pu_pkg::LEN_W-1:0];
                quo_reg <= {quo_reg[aco_pu_pkg::DIVIDEND_W-2:0], take};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/aco_pheromone_update.sv -----
// Ant System pheromone engine: pheromone and deposit stores in two RAMs,
// a serial divider for deposits and a read-modify-write sequencer.
// Depends on aco_pu_pkg, aco_pu_ram and aco_pu_div.
//
//  channel   | direction | payload                                   | transfer
//  ----------+-----------+-------------------------------------------+--------------------
//  s_ (item) | in        | tuser: operation; tdata: from, to, length | s_tvalid & s_tready
//  m_ (res)  | out       | tdata: pheromone_value; tuser: saturated  | m_tvalid & m_tready
//  cfg_      | in        | cfg_index, cfg_data                       | cfg_valid & cfg_ready
//
// One item at a time. A deposit runs the serial divider, then a read and a write of the
// accumulator per edge direction (only one direction on the diagonal), then loads the
// output. A commit walks all CITY_COUNT*CITY_COUNT entries, one entry per cycle; a read
// reads one entry; a bad city (deposit, read) or an unknown operation goes straight to the output.
// s_tready returns as the result loads. After reset a clearing pass over all entries
// holds s_tready low; cfg_ready is always high.
module aco_pheromone_update #(
    parameter int CITY_COUNT = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // from_city[4:0], to_city[9:5], tour_length[33:10], zero
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pheromone_value[31:0]
    output logic        m_tuser,   // saturated[0]
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int ENTRY_COUNT = CITY_COUNT * CITY_COUNT;
    localparam int ADDR_W      = $clog2(ENTRY_COUNT);
    localparam int CNT_W       = $clog2(ENTRY_COUNT + 1);
    localparam int MUL_W       = ADDR_W + aco_pu_pkg::CITY_W;
    localparam int VALUE_W     = aco_pu_pkg::VALUE_W;
    localparam int RET_W       = aco_pu_pkg::RET_W;
    localparam int PROD_W      = VALUE_W + RET_W;
    localparam logic [8:0]        CITY_LIM  = 9'(CITY_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRY_COUNT - 1);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DIV    = 9'b000000100,
        S_ACC_RD = 9'b000001000,
        S_ACC_WR = 9'b000010000,
        S_WALK   = 9'b000100000,
        S_READ   = 9'b001000000,
        S_RDATA  = 9'b010000000,
        S_RESULT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Input fields
    logic [aco_pu_pkg::CITY_W-1:0] in_from, in_to;
    logic [aco_pu_pkg::LEN_W-1:0]  in_len;
    aco_pu_pkg::op_t               in_op;
    logic                          in_ok;
    logic [ADDR_W-1:0]             in_ab, in_ba;
    logic                          accept;

    // Item and sequencer registers
    logic [ADDR_W-1:0]  ab_reg, ba_reg;
    logic               second_reg;
    logic [VALUE_W-1:0] amount_reg;
    logic               sat_reg;
    logic [VALUE_W-1:0] res_value_reg;
    logic [CNT_W-1:0]   walk_rd_reg;
    logic [ADDR_W-1:0]  walk_wr_reg;
    logic               walk_wv_reg;
    logic [ADDR_W-1:0]  clr_reg;

    // Configuration registers
    logic [VALUE_W-1:0] num_reg;
    logic [RET_W-1:0]   ret_reg;

    // Output register
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_sat_reg;
    logic               out_free;

    // RAM ports
    logic               pher_we, acc_we;
    logic [ADDR_W-1:0]  pher_waddr, acc_waddr, pher_raddr, acc_raddr;
    logic [VALUE_W-1:0] pher_wdata, acc_wdata, pher_rdata, acc_rdata;

    // Datapath
    logic               div_start, div_done;
    logic [aco_pu_pkg::DIVIDEND_W-1:0] div_quot;
    logic               div_over;
    logic [ADDR_W-1:0]  cur_addr;
    logic [VALUE_W:0]   acc_sum;
    logic               acc_clip;
    logic [PROD_W-1:0]  prod;
    logic [VALUE_W:0]   commit_sum;
    logic               commit_clip;
    logic               walk_issue;

    // Unpack the input item and form both edge addresses
    always_comb begin
        in_from = s_tdata[4:0];
        in_to   = s_tdata[9:5];
        in_len  = s_tdata[33:10];
        in_op   = aco_pu_pkg::op_t'(s_tuser);
        in_ok   = ({4'd0, in_from} < CITY_LIM) && ({4'd0, in_to} < CITY_LIM);
        in_ab   = ADDR_W'(MUL_W'(in_from) * MUL_W'(CITY_COUNT) + MUL_W'(in_to));
        in_ba   = ADDR_W'(MUL_W'(in_to) * MUL_W'(CITY_COUNT) + MUL_W'(in_from));
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    // Deposit amount from the divider, clipped to 32 bits
    assign div_start = accept && (in_op == aco_pu_pkg::OP_DEPOSIT) && in_ok;
    assign div_over  = |div_quot[aco_pu_pkg::DIVIDEND_W-1:VALUE_W];

    aco_pu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({num_reg, 4'd0}),
        .divisor  (in_len),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Accumulate and commit arithmetic on the RAM read data
    always_comb begin
        cur_addr    = second_reg ? ba_reg : ab_reg;
        acc_sum     = {1'b0, acc_rdata} + {1'b0, amount_reg};
        acc_clip    = acc_sum[VALUE_W];
        prod        = PROD_W'(pher_rdata) * PROD_W'(ret_reg);
        commit_sum  = {1'b0, prod[PROD_W-1:RET_W]} + {1'b0, acc_rdata};
        commit_clip = commit_sum[VALUE_W];
        walk_issue  = (state_reg == S_WALK) && (walk_rd_reg < CNT_W'(ENTRY_COUNT));
    end

    // RAM port steering
    always_comb begin
        pher_raddr = (state_reg == S_WALK) ? walk_rd_reg[ADDR_W-1:0] : ab_reg;
        acc_raddr  = (state_reg == S_WALK) ? walk_rd_reg[ADDR_W-1:0] : cur_addr;

        pher_we    = (state_reg == S_CLEAR) || ((state_reg == S_WALK) && walk_wv_reg);
        pher_waddr = (state_reg == S_CLEAR) ? clr_reg : walk_wr_reg;
        pher_wdata = (state_reg == S_CLEAR) ? aco_pu_pkg::ONE_Q16
                   : (commit_clip ? aco_pu_pkg::VALUE_MAX : commit_sum[VALUE_W-1:0]);

        acc_we     = (state_reg == S_CLEAR) || (state_reg == S_ACC_WR)
                   || ((state_reg == S_WALK) && walk_wv_reg);
        acc_waddr  = (state_reg == S_CLEAR) ? clr_reg
                   : ((state_reg == S_WALK) ? walk_wr_reg : cur_addr);
        acc_wdata  = (state_reg == S_ACC_WR)
                   ? (acc_clip ? aco_pu_pkg::VALUE_MAX : acc_sum[VALUE_W-1:0]) : '0;
    end

    aco_pu_ram #(
        .DEPTH  (ENTRY_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_W)
    ) u_pher_ram (
        .aclk  (aclk),
        .we    (pher_we),
        .waddr (pher_waddr),
        .wdata (pher_wdata),
        .raddr (pher_raddr),
        .rdata (pher_rdata)
    );

    aco_pu_ram #(
        .DEPTH  (ENTRY_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_W)
    ) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_reg == LAST_ADDR) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        aco_pu_pkg::OP_DEPOSIT: state_next = in_ok ? S_DIV : S_RESULT;
                        aco_pu_pkg::OP_COMMIT:  state_next = S_WALK;
                        aco_pu_pkg::OP_READ:    state_next = in_ok ? S_READ : S_RESULT;
                        default:                state_next = S_RESULT;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) state_next = S_ACC_RD;
            end
            S_ACC_RD: state_next = S_ACC_WR;
            S_ACC_WR: begin
                state_next = (!second_reg && (ab_reg != ba_reg)) ? S_ACC_RD : S_RESULT;
            end
            S_WALK: begin
                if (!walk_issue && walk_wv_reg) state_next = S_RESULT;
            end
            S_READ:  state_next = S_RDATA;
            S_RDATA: state_next = S_RESULT;
            S_RESULT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            walk_wv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Advance the clearing pass
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end

            // Latch the item and clear per-item status
            if (accept) begin
                ab_reg        <= in_ab;
                ba_reg        <= in_ba;
                second_reg    <= 1'b0;
                sat_reg       <= 1'b0;
                res_value_reg <= '0;
                walk_rd_reg   <= '0;
                walk_wv_reg   <= 1'b0;
            end

            // Take the quotient
            if ((state_reg == S_DIV) && div_done) begin
                amount_reg <= div_over ? aco_pu_pkg::VALUE_MAX : div_quot[VALUE_W-1:0];
                sat_reg    <= sat_reg | div_over;
            end

            // Write back one edge direction, then switch to the mirror entry
            if (state_reg == S_ACC_WR) begin
                sat_reg    <= sat_reg | acc_clip;
                second_reg <= 1'b1;
            end

            // Walk the matrix: read one entry, write the previous one
            if (state_reg == S_WALK) begin
                walk_wv_reg <= walk_issue;
                walk_wr_reg <= walk_rd_reg[ADDR_W-1:0];
                walk_rd_reg <= walk_rd_reg + CNT_W'(walk_issue);
                if (walk_wv_reg) begin
                    sat_reg <= sat_reg | commit_clip;
                end
            end

            // Capture the entry read
            if (state_reg == S_RDATA) begin
                res_value_reg <= pher_rdata;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_reg <= aco_pu_pkg::NUMERATOR_RST;
            ret_reg <= aco_pu_pkg::RETENTION_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                aco_pu_pkg::CFG_NUMERATOR: num_reg <= cfg_data;
                aco_pu_pkg::CFG_RETENTION: ret_reg <= cfg_data[RET_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register: load the result, drop valid after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((state_reg == S_RESULT) && out_free) begin
            out_valid_reg <= 1'b1;
            out_value_reg <= res_value_reg;
            out_sat_reg   <= sat_reg;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_sat_reg;

endmodule

// ----- sv/aco_pu_checker.sv -----
// Port-level checker for the pheromone update engine, with its bind.
// Depends only on the top level's ports.
module aco_pu_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Refuse items during the clearing pass that follows reset
    assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("item taken before the clearing pass");

    // One item at a time: drop ready after each input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in progress");

    // A new result appears only as an item finishes, never from idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while idle");

endmodule

bind aco_pheromone_update aco_pu_port_checker u_checker (.*);

// ----- test/aco_pu_checker.sv -----
// Checker for the pheromone update engine: watches the item, result and
// register channels, predicts every result and compares it field by field.
// Depends on aco_pu_pkg.
`timescale 1ns / 100ps

module aco_pu_checker #(
    parameter int CITY_COUNT = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // from_city[4:0], to_city[9:5], tour_length[33:10], zero
    input  logic [1:0]  s_tuser,   // operation[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // pheromone_value[31:0]
    input  logic        m_tuser,   // saturated[0]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          pending
);

    localparam int ENTRIES = CITY_COUNT * CITY_COUNT;
    localparam int VALUE_W = aco_pu_pkg::VALUE_W;
    localparam int RET_W   = aco_pu_pkg::RET_W;
    localparam int LEN_W   = aco_pu_pkg::LEN_W;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               saturated;
    } result_t;

    // Shadow copy of the engine state and registers
    logic [VALUE_W-1:0] trail_level [ENTRIES];
    logic [VALUE_W-1:0] deposit_sum [ENTRIES];
    logic [VALUE_W-1:0] numerator_q;
    logic [RET_W-1:0]   retention_q;
    result_t            expected_q [$];
    int                 fail_total = 0;

    assign mismatches = fail_total;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        fail_total++;
        $display("aco_pu_checker: %s mismatch at %0t: expected %h, got %h",
                 what, $time, want, got);
    endtask

    // Add a deposit to one accumulator entry; return 1 when it clips
    function automatic bit accumulate(input int idx, input logic [VALUE_W-1:0] amount);
        logic [VALUE_W:0] sum;
        sum = {1'b0, deposit_sum[idx]} + {1'b0, amount};
        deposit_sum[idx] = sum[VALUE_W] ? aco_pu_pkg::VALUE_MAX : sum[VALUE_W-1:0];
        return sum[VALUE_W];
    endfunction

    // Apply one item to the shadow state and return the result it yields
    function automatic result_t apply_item(input logic [1:0] op, input logic [4:0] city_a,
                                           input logic [4:0] city_b,
                                           input logic [LEN_W-1:0] len);
        result_t            res;
        logic [35:0]        quotient;
        logic [VALUE_W-1:0] amount;
        logic [63:0]        merged;
        int                 ab;
        int                 ba;
        bit                 in_range;
        res      = '0;
        in_range = (int'(city_a) < CITY_COUNT) && (int'(city_b) < CITY_COUNT);
        ab       = int'(city_a) * CITY_COUNT + int'(city_b);
        ba       = int'(city_b) * CITY_COUNT + int'(city_a);
        case (op)
            aco_pu_pkg::OP_DEPOSIT: begin
                if (in_range) begin
                    // zero length forces a clipped deposit
                    if (len == '0) begin
                        amount        = aco_pu_pkg::VALUE_MAX;
                        res.saturated = 1'b1;
                    end else begin
                        quotient = {numerator_q, 4'b0000} / len;
                        if (quotient > 36'(aco_pu_pkg::VALUE_MAX)) begin
                            amount        = aco_pu_pkg::VALUE_MAX;
                            res.saturated = 1'b1;
                        end else begin
                            amount = quotient[VALUE_W-1:0];
                        end
                    end
                    if (accumulate(ab, amount))
                        res.saturated = 1'b1;
                    // diagonal edge gets a single deposit
                    if (ab != ba && accumulate(ba, amount))
                        res.saturated = 1'b1;
                end
            end
            aco_pu_pkg::OP_COMMIT: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    merged = ((64'(trail_level[i]) * 64'(retention_q)) >> 16)
                             + 64'(deposit_sum[i]);
                    if (merged > 64'(aco_pu_pkg::VALUE_MAX)) begin
                        trail_level[i] = aco_pu_pkg::VALUE_MAX;
                        res.saturated  = 1'b1;
                    end else begin
                        trail_level[i] = merged[VALUE_W-1:0];
                    end
                    deposit_sum[i] = '0;
                end
            end
            aco_pu_pkg::OP_READ: begin
                if (in_range)
                    res.value = trail_level[ab];
            end
            default: ;
        endcase
        return res;
    endfunction

    // Track every transfer: registers, then results, then new items
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                trail_level[i] = aco_pu_pkg::ONE_Q16;
                deposit_sum[i] = '0;
            end
            numerator_q = aco_pu_pkg::NUMERATOR_RST;
            retention_q = aco_pu_pkg::RETENTION_RST;
            expected_q.delete();
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    aco_pu_pkg::CFG_NUMERATOR: numerator_q = cfg_data;
                    aco_pu_pkg::CFG_RETENTION: retention_q = cfg_data[RET_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, m_tdata);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch("pheromone_value", want.value, m_tdata);
                    if (m_tuser !== want.saturated)
                        report_mismatch("saturated", 32'(want.saturated), 32'(m_tuser));
                end
            end
            if (s_tvalid && s_tready)
                expected_q.insert(expected_q.size(),
                                  apply_item(s_tuser, s_tdata[4:0], s_tdata[9:5],
                                             s_tdata[33:10]));
            pending <= expected_q.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the pheromone update engine: clock, reset, item and
// register stimulus, result back-pressure, watchdog and final verdict.
// Depends on aco_pu_pkg, aco_pheromone_update and aco_pu_checker.
`timescale 1ns / 100ps

module tb_top;

    localparam int         CITY_COUNT     = 32;
    localparam int         WATCHDOG_LIMIT = 8000;
    localparam logic [1:0] OP_UNKNOWN     = 2'd3;
    localparam logic [1:0] OP_DEPOSIT     = aco_pu_pkg::OP_DEPOSIT;
    localparam logic [1:0] OP_COMMIT      = aco_pu_pkg::OP_COMMIT;
    localparam logic [1:0] OP_READ        = aco_pu_pkg::OP_READ;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;   // from_city[4:0], to_city[9:5], tour_length[33:10], zero
    logic [1:0]  s_tuser   = '0;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // pheromone_value[31:0]
    logic        m_tuser;          // saturated[0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    int mismatches;
    int pending;
    int idle_pct     = 30;
    int stall_left   = 0;
    int quiet_cycles = 0;

    always #2 aclk = ~aclk;

    aco_pheromone_update #(.CITY_COUNT(CITY_COUNT)) u_top (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    aco_pu_checker #(.CITY_COUNT(CITY_COUNT)) u_checker (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .mismatches, .pending
    );

    // Stall the result side in random bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct / 3) begin
            stall_left <= $urandom_range(7);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item, after an optional gap, and hold it until the transfer
    task automatic send_item(input logic [1:0] op, input logic [4:0] city_a,
                             input logic [4:0] city_b, input logic [23:0] len);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, len, city_b, city_a};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and wait until every result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Write both registers back to back
    task automatic write_regs(input logic [31:0] numerator, input logic [15:0] keep);
        cfg_valid <= 1'b1;
        cfg_index <= aco_pu_pkg::CFG_NUMERATOR;
        cfg_data  <= numerator;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= aco_pu_pkg::CFG_RETENTION;
        cfg_data  <= {16'b0, keep};
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random mix of deposits, reads, commits and a few unknown operations
    task automatic run_random(input int count);
        int          r;
        logic [4:0]  fa;
        logic [4:0]  ta;
        logic [4:0]  last_a;
        logic [4:0]  last_b;
        logic [23:0] len;
        last_a = '0;
        last_b = '0;
        for (int k = 0; k < count; k++) begin
            r  = $urandom_range(99);
            fa = 5'($urandom_range(31));
            ta = ($urandom_range(6) == 0) ? fa : 5'($urandom_range(31));
            if (r < 58) begin
                case ($urandom_range(3))
                    0:       len = 24'($urandom_range(15, 1));
                    1:       len = 24'($urandom_range(4095, 16));
                    2:       len = 24'($urandom_range(24'hFF_FFFF, 1));
                    default: len = 24'($urandom_range(24'hFF_FFFF, 24'h80_0000));
                endcase
                if ($urandom_range(49) == 0)
                    len = '0;
                send_item(OP_DEPOSIT, fa, ta, len);
                last_a = fa;
                last_b = ta;
            end else if (r < 88) begin
                // read back the last deposited edge half of the time
                if ($urandom_range(1))
                    send_item(OP_READ, last_b, last_a, 24'($urandom));
                else
                    send_item(OP_READ, fa, ta, 24'($urandom));
            end else if (r < 97) begin
                send_item(OP_COMMIT, fa, ta, 24'($urandom));
            end else begin
                send_item(OP_UNKNOWN, fa, ta, 24'($urandom));
            end
        end
    endtask

    initial begin
        logic [31:0] num;
        logic [15:0] keep;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: initial values, both edge directions, diagonal, zero length
        send_item(OP_READ, 5'd0, 5'd0, 24'd0);
        send_item(OP_READ, 5'd31, 5'd31, 24'hFF_FFFF);
        send_item(OP_DEPOSIT, 5'd0, 5'd31, 24'd16);
        send_item(OP_DEPOSIT, 5'd5, 5'd5, 24'd1);
        send_item(OP_DEPOSIT, 5'd31, 5'd0, 24'hFF_FFFF);
        send_item(OP_DEPOSIT, 5'd3, 5'd4, 24'd0);
        send_item(OP_DEPOSIT, 5'd3, 5'd4, 24'd0);
        send_item(OP_UNKNOWN, 5'd31, 5'd31, 24'hFF_FFFF);
        send_item(OP_READ, 5'd0, 5'd31, 24'd0);
        send_item(OP_COMMIT, 5'd0, 5'd0, 24'd0);
        send_item(OP_READ, 5'd31, 5'd0, 24'd0);
        send_item(OP_READ, 5'd5, 5'd5, 24'd0);
        send_item(OP_READ, 5'd4, 5'd3, 24'd0);

        // Largest numerator and retention: clipped quotient and clipped merge
        wait_drained();
        write_regs(aco_pu_pkg::VALUE_MAX, 16'hFFFF);
        send_item(OP_DEPOSIT, 5'd1, 5'd2, 24'd1);
        send_item(OP_DEPOSIT, 5'd31, 5'd31, 24'hFF_FFFF);
        send_item(OP_COMMIT, 5'd31, 5'd31, 24'hFF_FFFF);
        send_item(OP_READ, 5'd2, 5'd1, 24'd0);
        send_item(OP_READ, 5'd31, 5'd31, 24'd0);
        send_item(OP_READ, 5'd3, 5'd4, 24'd0);

        // Zero numerator and retention: everything decays to zero
        wait_drained();
        write_regs('0, '0);
        send_item(OP_DEPOSIT, 5'd7, 5'd8, 24'd5);
        send_item(OP_COMMIT, 5'd0, 5'd0, 24'd0);
        send_item(OP_READ, 5'd8, 5'd7, 24'd0);
        send_item(OP_READ, 5'd0, 5'd0, 24'd0);

        // Random phases under changing settings; the last one runs without idling
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            case (p)
                0: begin
                    num  = aco_pu_pkg::VALUE_MAX;
                    keep = 16'hFFFF;
                end
                1: begin
                    num  = '0;
                    keep = '0;
                end
                2: begin
                    num  = $urandom;
                    keep = 16'($urandom);
                end
                3: begin
                    num  = aco_pu_pkg::NUMERATOR_RST;
                    keep = aco_pu_pkg::RETENTION_RST;
                end
                4: begin
                    num  = $urandom >> $urandom_range(16);
                    keep = 16'hFFFF;
                end
                default: begin
                    num  = $urandom >> $urandom_range(8);
                    keep = 16'($urandom);
                end
            endcase
            idle_pct = (p == 2 || p == 5) ? 0 : 35;
            write_regs(num, keep);
            run_random(64);
        end

        wait_drained();
        repeat (64) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
